>>> rtl/epipolar_residual_unit_macros.svh
// Assertion macros for the epipolar residual unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef EPIPOLAR_RESIDUAL_UNIT_MACROS_SVH
`define EPIPOLAR_RESIDUAL_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ERU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("epipolar residual unit: assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ERU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("epipolar residual unit: assertion failed");

`endif

>>> rtl/eru_pkg.sv
// Shared widths, latencies, register indexes and types of the epipolar residual unit.
// Has no dependencies; every RTL module imports it.
`default_nettype none
package eru_pkg;

  localparam int COEF_W          = 32;
  localparam int COORD_W         = 18;
  localparam int COORD_FRAC_BITS = 4;
  localparam int RES_W           = 32;
  localparam int RES_FRAC        = 12;
  localparam int SQRT_FRAC       = 2 * RES_FRAC;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 3;

  localparam int PROD_W   = COEF_W + COORD_W;
  localparam int AB_W     = PROD_W + 2;
  localparam int SQ_SPLIT = AB_W / 2;
  localparam int SQ_W     = 2 * AB_W;
  localparam int DA_W     = SQ_W + 1;
  localparam int DSUM_W   = DA_W + 1;
  localparam int E_W      = 72;
  localparam int E_SPLIT  = E_W / 3;
  localparam int E2_W     = 2 * E_W;
  localparam int NUM_W    = E2_W + SQRT_FRAC;
  localparam int DEN_W    = DSUM_W + 2 * COORD_FRAC_BITS;
  localparam int Q_W      = 64;
  localparam int ROOT_W   = Q_W / 2;

  localparam int FRONT_LAT = 7;
  localparam int DIV_LAT   = Q_W + 1;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int SIDE_LAT  = DIV_LAT + SQRT_LAT;

  typedef logic [8:0][COEF_W-1:0] coef_set_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PAIR_A = 3'd0,
    CFG_PAIR_B = 3'd1,
    CFG_PAIR_C = 3'd2,
    CFG_PAIR_D = 3'd3,
    CFG_LAST   = 3'd4,
    CFG_MODE   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic valid;
    logic mode;
    logic deg;
  } side_t;

  typedef struct packed {
    logic              ovf_a;
    logic              ovf_b;
    logic              hi_nz;
    logic [RES_W-1:0]  lo;
  } post_t;

endpackage
`default_nettype wire

>>> rtl/eru_front.sv
// Product stages: forms F x1, F^T x2, the constraint, its square and the sums of squares.
// Depends on eru_pkg.
`default_nettype none
module eru_front import eru_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ce,
  input  logic                      in_valid,
  input  logic                      in_mode,
  input  coef_set_t                 coef,
  input  logic signed [COORD_W-1:0] x1,
  input  logic signed [COORD_W-1:0] y1,
  input  logic signed [COORD_W-1:0] x2,
  input  logic signed [COORD_W-1:0] y2,
  output logic                      out_valid,
  output logic                      out_mode,
  output logic [E2_W-1:0]           e2,
  output logic [DA_W-1:0]           da,
  output logic [DA_W-1:0]           db
);

  logic [FRONT_LAT-1:0] vld;
  logic [FRONT_LAT-1:0] mde;

  logic signed [PROD_W-1:0]  s1_pa [6];
  logic signed [PROD_W-1:0]  s1_pb [4];
  logic signed [PROD_W-1:0]  s1_ca [3];
  logic signed [PROD_W-1:0]  s1_cb [2];
  logic signed [COORD_W-1:0] s1_x2, s1_y2;

  logic signed [AB_W-1:0]    s2_a [3];
  logic signed [AB_W-1:0]    s2_b [2];
  logic signed [COORD_W-1:0] s2_x2, s2_y2;

  logic signed [E_W-1:0]     s3_t [3];
  logic [AB_W-1:0]           s3_mag [4];

  logic signed [E_W-1:0]     s4_e;
  logic [2*SQ_SPLIT-1:0]     s4_hh [4];
  logic [2*SQ_SPLIT-1:0]     s4_hl [4];
  logic [2*SQ_SPLIT-1:0]     s4_ll [4];

  logic [E_W-1:0]            s5_emag;
  logic [SQ_W-1:0]           s5_sq [4];

  logic [2*E_SPLIT-1:0]      s6_p22, s6_p21, s6_p20, s6_p11, s6_p10, s6_p00;
  logic [DA_W-1:0]           s6_da, s6_db;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[FRONT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mde <= {mde[FRONT_LAT-2:0], in_mode};
      // Stage 1: coefficient times coordinate products.
      for (int i = 0; i < 3; i++) begin
        s1_pa[2*i]   <= $signed(coef[3*i])   * x1;
        s1_pa[2*i+1] <= $signed(coef[3*i+1]) * y1;
        s1_ca[i]     <= PROD_W'($signed(coef[3*i+2])) <<< COORD_FRAC_BITS;
      end
      for (int i = 0; i < 2; i++) begin
        s1_pb[2*i]   <= $signed(coef[i])   * x2;
        s1_pb[2*i+1] <= $signed(coef[3+i]) * y2;
        s1_cb[i]     <= PROD_W'($signed(coef[6+i])) <<< COORD_FRAC_BITS;
      end
      s1_x2 <= x2;
      s1_y2 <= y2;
      // Stage 2: the epipolar line components.
      for (int i = 0; i < 3; i++) begin
        s2_a[i] <= AB_W'(s1_pa[2*i]) + AB_W'(s1_pa[2*i+1]) + AB_W'(s1_ca[i]);
      end
      for (int i = 0; i < 2; i++) begin
        s2_b[i] <= AB_W'(s1_pb[2*i]) + AB_W'(s1_pb[2*i+1]) + AB_W'(s1_cb[i]);
      end
      s2_x2 <= s1_x2;
      s2_y2 <= s1_y2;
      // Stage 3: constraint terms and magnitudes of the line components.
      s3_t[0] <= E_W'(s2_x2) * E_W'(s2_a[0]);
      s3_t[1] <= E_W'(s2_y2) * E_W'(s2_a[1]);
      s3_t[2] <= E_W'(s2_a[2]) <<< COORD_FRAC_BITS;
      s3_mag[0] <= s2_a[0][AB_W-1] ? AB_W'(-s2_a[0]) : AB_W'(s2_a[0]);
      s3_mag[1] <= s2_a[1][AB_W-1] ? AB_W'(-s2_a[1]) : AB_W'(s2_a[1]);
      s3_mag[2] <= s2_b[0][AB_W-1] ? AB_W'(-s2_b[0]) : AB_W'(s2_b[0]);
      s3_mag[3] <= s2_b[1][AB_W-1] ? AB_W'(-s2_b[1]) : AB_W'(s2_b[1]);
      // Stage 4: constraint sum and half-word partial squares.
      s4_e <= s3_t[0] + s3_t[1] + s3_t[2];
      for (int k = 0; k < 4; k++) begin
        s4_hh[k] <= s3_mag[k][AB_W-1:SQ_SPLIT] * s3_mag[k][AB_W-1:SQ_SPLIT];
        s4_hl[k] <= s3_mag[k][AB_W-1:SQ_SPLIT] * s3_mag[k][SQ_SPLIT-1:0];
        s4_ll[k] <= s3_mag[k][SQ_SPLIT-1:0] * s3_mag[k][SQ_SPLIT-1:0];
      end
      // Stage 5: constraint magnitude and assembled squares.
      s5_emag <= s4_e[E_W-1] ? E_W'(-s4_e) : E_W'(s4_e);
      for (int k = 0; k < 4; k++) begin
        s5_sq[k] <= (SQ_W'(s4_hh[k]) << (2*SQ_SPLIT)) + (SQ_W'(s4_hl[k]) << (SQ_SPLIT+1))
                    + SQ_W'(s4_ll[k]);
      end
      // Stage 6: partial products of the constraint square, sums of squares.
      s6_p22 <= s5_emag[3*E_SPLIT-1:2*E_SPLIT] * s5_emag[3*E_SPLIT-1:2*E_SPLIT];
      s6_p21 <= s5_emag[3*E_SPLIT-1:2*E_SPLIT] * s5_emag[2*E_SPLIT-1:E_SPLIT];
      s6_p20 <= s5_emag[3*E_SPLIT-1:2*E_SPLIT] * s5_emag[E_SPLIT-1:0];
      s6_p11 <= s5_emag[2*E_SPLIT-1:E_SPLIT] * s5_emag[2*E_SPLIT-1:E_SPLIT];
      s6_p10 <= s5_emag[2*E_SPLIT-1:E_SPLIT] * s5_emag[E_SPLIT-1:0];
      s6_p00 <= s5_emag[E_SPLIT-1:0] * s5_emag[E_SPLIT-1:0];
      s6_da  <= DA_W'(s5_sq[0]) + DA_W'(s5_sq[1]);
      s6_db  <= DA_W'(s5_sq[2]) + DA_W'(s5_sq[3]);
      // Stage 7: the constraint squared.
      e2 <= (E2_W'(s6_p22) << (4*E_SPLIT)) + (E2_W'(s6_p21) << (3*E_SPLIT+1))
            + (E2_W'(s6_p20) << (2*E_SPLIT+1)) + (E2_W'(s6_p11) << (2*E_SPLIT))
            + (E2_W'(s6_p10) << (E_SPLIT+1)) + E2_W'(s6_p00);
      da <= s6_da;
      db <= s6_db;
    end
  end

  assign out_valid = vld[FRONT_LAT-1];
  assign out_mode  = mde[FRONT_LAT-1];

endmodule
`default_nettype wire

>>> rtl/eru_div.sv
// Pipelined restoring divider: one quotient bit per stage, overflow check up front.
// Depends on eru_pkg.
`default_nettype none
module eru_div import eru_pkg::*; (
  input  logic             clk,
  input  logic             ce,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot,
  output logic             ovf
);

  localparam int WW = DEN_W + Q_W;

  logic [NUM_W-1:0] rem   [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  logic             ovf_r [Q_W+1];

  // Stage 0: the quotient must fit in Q_W bits.
  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0]   <= num;
      den_r[0] <= den;
      q_r[0]   <= '0;
      ovf_r[0] <= WW'(num) >= (WW'(den) << Q_W);
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    localparam int SH = Q_W - k;
    logic [WW-1:0] dsh;
    logic          ge;
    assign dsh = WW'(den_r[k-1]) << SH;
    assign ge  = WW'(rem[k-1]) >= dsh;
    always_ff @(posedge clk) begin
      if (ce) begin
        q_r[k]   <= q_r[k-1] | (ge ? (Q_W'(1) << SH) : '0);
        ovf_r[k] <= ovf_r[k-1];
      end
    end
    if (k < Q_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem[k]   <= ge ? NUM_W'(WW'(rem[k-1]) - dsh) : rem[k-1];
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quot = q_r[Q_W];
  assign ovf  = ovf_r[Q_W];

endmodule
`default_nettype wire

>>> rtl/eru_sqrt.sv
// Pipelined integer square root: one result bit per stage, floor of the root.
// Depends on eru_pkg.
`default_nettype none
module eru_sqrt import eru_pkg::*; (
  input  logic              clk,
  input  logic              ce,
  input  logic [Q_W-1:0]    val,
  output logic [ROOT_W-1:0] root
);

  logic [Q_W-1:0] nv [SQRT_LAT];
  logic [Q_W-1:0] rv [SQRT_LAT+1];

  assign nv[0] = val;
  assign rv[0] = '0;

  for (genvar k = 1; k <= SQRT_LAT; k++) begin : g_stage
    localparam int BITPOS = Q_W - 2 * k;
    logic [Q_W:0] trial;
    logic         ge;
    assign trial = (Q_W+1)'(rv[k-1]) + ((Q_W+1)'(1) << BITPOS);
    assign ge    = (Q_W+1)'(nv[k-1]) >= trial;
    always_ff @(posedge clk) begin
      if (ce) begin
        rv[k] <= ge ? ((rv[k-1] >> 1) + (Q_W'(1) << BITPOS)) : (rv[k-1] >> 1);
      end
    end
    if (k < SQRT_LAT) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          nv[k] <= ge ? Q_W'((Q_W+1)'(nv[k-1]) - trial) : nv[k-1];
        end
      end
    end
  end

  assign root = rv[SQRT_LAT][ROOT_W-1:0];

endmodule
`default_nettype wire

>>> rtl/epipolar_residual_unit.sv
// Top level of the epipolar residual unit: registers, divider and root pipelines, output.
// Depends on eru_pkg, eru_front, eru_div, eru_sqrt and the assertion macro header.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------------------
//   input    | in_valid / in_ready   | first_x, first_y, second_x, second_y
//   result   | out_valid / out_ready | residual, degenerate, clipped
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One transaction enters per cycle while in_ready is high; each result passes through
// 7 product stages, 65 divider stages, 32 root stages and the output register.
// Two 64-step restoring dividers and two 32-step root pipelines run side by side.
// Reset (rst, synchronous) clears the configuration registers and every valid bit, which
// empties the pipeline; the data registers are left as they are.
// When a result waits, one more finished item is held in a skid register; only when
// that is full does the whole pipeline stall, and in_ready falls with it.
`default_nettype none
`include "epipolar_residual_unit_macros.svh"
module epipolar_residual_unit import eru_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] first_x,
  input  logic signed [COORD_W-1:0] first_y,
  input  logic signed [COORD_W-1:0] second_x,
  input  logic signed [COORD_W-1:0] second_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [RES_W-1:0]          residual,
  output logic                      degenerate,
  output logic                      clipped,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers. The coefficients are held as written; the pairs
  // are split into the nine entries of F below.
  logic [CFG_DATA_W-1:0] pair_a, pair_b, pair_c, pair_d;
  logic [COEF_W-1:0]     coef_last;
  logic                  score_mode;
  coef_set_t             coef;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_a     <= '0;
      pair_b     <= '0;
      pair_c     <= '0;
      pair_d     <= '0;
      coef_last  <= '0;
      score_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_PAIR_A: pair_a     <= cfg_data;
        CFG_PAIR_B: pair_b     <= cfg_data;
        CFG_PAIR_C: pair_c     <= cfg_data;
        CFG_PAIR_D: pair_d     <= cfg_data;
        CFG_LAST:   coef_last  <= cfg_data[COEF_W-1:0];
        CFG_MODE:   score_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign coef[0] = pair_a[COEF_W-1:0];
  assign coef[1] = pair_a[CFG_DATA_W-1:COEF_W];
  assign coef[2] = pair_b[COEF_W-1:0];
  assign coef[3] = pair_b[CFG_DATA_W-1:COEF_W];
  assign coef[4] = pair_c[COEF_W-1:0];
  assign coef[5] = pair_c[CFG_DATA_W-1:COEF_W];
  assign coef[6] = pair_d[COEF_W-1:0];
  assign coef[7] = pair_d[CFG_DATA_W-1:COEF_W];
  assign coef[8] = coef_last;

  // The whole pipeline advances together while the skid register is empty.
  logic ce;
  logic skid_valid;
  assign ce       = !skid_valid;
  assign in_ready = ce;

  logic            fr_valid, fr_mode;
  logic [E2_W-1:0] fr_e2;
  logic [DA_W-1:0] fr_da, fr_db;

  eru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (in_valid),
    .in_mode   (score_mode),
    .coef      (coef),
    .x1        (first_x),
    .y1        (first_y),
    .x2        (second_x),
    .y2        (second_y),
    .out_valid (fr_valid),
    .out_mode  (fr_mode),
    .e2        (fr_e2),
    .da        (fr_da),
    .db        (fr_db)
  );

  // Divider operands. In Sampson mode divider A alone produces the score from the
  // total sum of squares; in distance mode both dividers give the squared distance
  // to each epipolar line with enough fraction bits for the square root.
  logic [DSUM_W-1:0] d_sum;
  logic [NUM_W-1:0]  num_a, num_b;
  logic [DEN_W-1:0]  den_a, den_b;
  logic              fr_deg;

  assign d_sum  = DSUM_W'(fr_da) + DSUM_W'(fr_db);
  assign num_a  = fr_mode ? (NUM_W'(fr_e2) << SQRT_FRAC) : (NUM_W'(fr_e2) << RES_FRAC);
  assign den_a  = fr_mode ? (DEN_W'(fr_da) << (2*COORD_FRAC_BITS))
                          : (DEN_W'(d_sum) << (2*COORD_FRAC_BITS));
  assign num_b  = NUM_W'(fr_e2) << SQRT_FRAC;
  assign den_b  = DEN_W'(fr_db) << (2*COORD_FRAC_BITS);
  assign fr_deg = fr_mode ? ((fr_da == '0) || (fr_db == '0)) : (d_sum == '0);

  logic [Q_W-1:0] q_a, q_b;
  logic           ovf_a, ovf_b;

  eru_div u_div_a (
    .clk  (clk),
    .ce   (ce),
    .num  (num_a),
    .den  (den_a),
    .quot (q_a),
    .ovf  (ovf_a)
  );

  eru_div u_div_b (
    .clk  (clk),
    .ce   (ce),
    .num  (num_b),
    .den  (den_b),
    .quot (q_b),
    .ovf  (ovf_b)
  );

  logic [ROOT_W-1:0] root_a, root_b;

  eru_sqrt u_sqrt_a (
    .clk  (clk),
    .ce   (ce),
    .val  (q_a),
    .root (root_a)
  );

  eru_sqrt u_sqrt_b (
    .clk  (clk),
    .ce   (ce),
    .val  (q_b),
    .root (root_b)
  );

  // Valid, mode and degenerate flag travel alongside the divider and root stages;
  // the divider flags and the Sampson quotient travel alongside the root stages.
  side_t side [SIDE_LAT];
  post_t post [SQRT_LAT];

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0].mode <= fr_mode;
      side[0].deg  <= fr_deg;
      for (int k = 1; k < SIDE_LAT; k++) begin
        side[k].mode <= side[k-1].mode;
        side[k].deg  <= side[k-1].deg;
      end
      post[0].ovf_a <= ovf_a;
      post[0].ovf_b <= ovf_b;
      post[0].hi_nz <= q_a[Q_W-1:RES_W] != '0;
      post[0].lo    <= q_a[RES_W-1:0];
      for (int k = 1; k < SQRT_LAT; k++) begin
        post[k] <= post[k-1];
      end
    end
    if (rst) begin
      for (int k = 0; k < SIDE_LAT; k++) begin
        side[k].valid <= 1'b0;
      end
    end else if (ce) begin
      side[0].valid <= fr_valid;
      for (int k = 1; k < SIDE_LAT; k++) begin
        side[k].valid <= side[k-1].valid;
      end
    end
  end

  // Final scoring. A zero denominator wins over any overflow.
  side_t             fin;
  post_t             pst;
  logic [RES_W:0]    root_sum;
  logic [RES_W-1:0]  res_new;
  logic              deg_new, clip_new;

  assign fin      = side[SIDE_LAT-1];
  assign pst      = post[SQRT_LAT-1];
  assign root_sum = (RES_W+1)'(root_a) + (RES_W+1)'(root_b);

  always_comb begin
    res_new  = '1;
    deg_new  = 1'b0;
    clip_new = 1'b0;
    if (fin.deg) begin
      deg_new = 1'b1;
    end else if (!fin.mode) begin
      if (pst.ovf_a || pst.hi_nz) begin
        clip_new = 1'b1;
      end else begin
        res_new = pst.lo;
      end
    end else begin
      if (pst.ovf_a || pst.ovf_b || root_sum[RES_W]) begin
        clip_new = 1'b1;
      end else begin
        res_new = root_sum[RES_W-1:0];
      end
    end
  end

  // Output register with one skid entry behind it.
  logic [RES_W-1:0] skid_res;
  logic             skid_deg, skid_clip;
  logic             take, load;

  assign take = out_valid && out_ready;
  assign load = ce && fin.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load && (!out_valid || take)) begin
        out_valid  <= 1'b1;
        residual   <= res_new;
        degenerate <= deg_new;
        clipped    <= clip_new;
      end else if (take) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          residual   <= skid_res;
          degenerate <= skid_deg;
          clipped    <= skid_clip;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
      if (load && out_valid && !take) begin
        skid_valid <= 1'b1;
        skid_res   <= res_new;
        skid_deg   <= deg_new;
        skid_clip  <= clip_new;
      end
    end
  end

  // A degenerate result carries the maximum score and no clip flag.
  `ERU_ASSERT_IMPL(a_deg_max, out_valid && degenerate, (residual == '1) && !clipped)
  // A clipped result is saturated.
  `ERU_ASSERT_IMPL(a_clip_max, out_valid && clipped, residual == '1)
  // The skid entry is only ever filled behind a waiting result.
  `ERU_ASSERT_IMPL(a_skid_behind, skid_valid, out_valid)
  // A full skid entry freezes the pipeline, so nothing is loaded in that cycle.
  `ERU_ASSERT_NEXT(a_skid_hold, skid_valid && !out_ready, skid_valid && $stable(skid_res))

endmodule
`default_nettype wire
